// ----- design/shm_pkg.sv -----
// Shared types and constants for the smoothed histogram mode block.
`default_nettype none
package shm_pkg;

  localparam int NUM_BINS     = 256;
  localparam int MAX_SET_SIZE = 4096;
  localparam int ADDR_W       = $clog2(NUM_BINS);
  localparam int SAMPLE_W     = 9;
  localparam int BIN_W        = 14;
  localparam int SUM_W        = BIN_W + 2;
  localparam int CNT_W        = ADDR_W + 1;

  localparam logic [BIN_W-1:0]  BIN_MAX = {BIN_W{1'b1}};
  localparam logic [ADDR_W-1:0] TIE_BIN = 8'h80;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] mode_value;
    logic              range_error;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic count;       // request accepted: count its sample
    logic scan_start;  // reset the scan counter
    logic scan_step;   // advance the bin scan
    logic finish;      // load result, clear histogram and error
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- design/shm_dp.sv -----
// Datapath: raw bin memory with increment, smoothing scan and mode search.
`default_nettype none
module shm_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  shm_pkg::in_item_t    in_data,
  input  shm_pkg::dp_cmd_t     cmd,
  output shm_pkg::dp_status_t  status,
  output shm_pkg::out_item_t   out_data
);
  import shm_pkg::*;

  // Raw counts (one per bin); smoothing 2*c[i]+c[i-1]+c[i+1] is done in the scan.
  // Adds are all positive, so saturating the raw counts and the sum gives the
  // same figure as saturating each of the three adds.
  logic [BIN_W-1:0]    mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld_r;

  logic [ADDR_W-1:0]   rd_addr;
  logic [BIN_W-1:0]    rd_data_r;
  logic                rd_vld_r;
  logic [BIN_W-1:0]    rd_cnt;

  logic                upd_vld_r;
  logic [ADDR_W-1:0]   upd_addr_r;
  logic                wr_vld_r;
  logic [ADDR_W-1:0]   wr_addr_r;
  logic [BIN_W-1:0]    wr_data_r;
  logic [BIN_W-1:0]    upd_cur;
  logic [BIN_W-1:0]    upd_val;

  logic                error_r;

  logic [CNT_W-1:0]    scan_cnt_r;
  logic                k_vld_r;
  logic [CNT_W-1:0]    k_r;
  logic [BIN_W-1:0]    k_cin;
  logic [BIN_W-1:0]    win_a_r;
  logic [BIN_W-1:0]    win_b_r;
  logic [SUM_W-1:0]    sum;
  logic [BIN_W-1:0]    smooth;
  logic [ADDR_W-1:0]   j_idx;
  logic [BIN_W-1:0]    best_val_r;
  logic [ADDR_W-1:0]   best_idx_r;
  logic [BIN_W-1:0]    tie_val_r;
  out_item_t           out_r;
  logic                scan_go;

  assign rd_addr = cmd.count ? in_data.sample[ADDR_W-1:0] : scan_cnt_r[ADDR_W-1:0];
  assign rd_cnt  = rd_vld_r ? rd_data_r : '0;

  // a read issued in the same cycle as the previous write misses it: forward
  assign upd_cur = (wr_vld_r && wr_addr_r == upd_addr_r) ? wr_data_r : rd_cnt;
  assign upd_val = (upd_cur == BIN_MAX) ? upd_cur : upd_cur + 1'b1;

  assign scan_go = cmd.scan_step && (scan_cnt_r <= CNT_W'(NUM_BINS));

  // past the top bin the neighbour is absent
  assign k_cin  = k_r[ADDR_W] ? '0 : rd_cnt;
  assign sum    = {1'b0, win_b_r, 1'b0} + SUM_W'(win_a_r) + SUM_W'(k_cin);
  assign smooth = (sum > SUM_W'(BIN_MAX)) ? BIN_MAX : sum[BIN_W-1:0];
  assign j_idx  = k_r[ADDR_W-1:0] - 1'b1;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
    if (upd_vld_r) begin
      mem[upd_addr_r] <= upd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      upd_vld_r  <= 1'b0;
      wr_vld_r   <= 1'b0;
      error_r    <= 1'b0;
      scan_cnt_r <= '0;
      k_vld_r    <= 1'b0;
    end else begin
      upd_vld_r <= cmd.count && !in_data.sample[SAMPLE_W-1];
      wr_vld_r  <= upd_vld_r;
      if (cmd.finish) begin
        vld_r   <= '0;
        error_r <= 1'b0;
      end else begin
        if (upd_vld_r) begin
          vld_r[upd_addr_r] <= 1'b1;
        end
        if (cmd.count && in_data.sample[SAMPLE_W-1]) begin
          error_r <= 1'b1;
        end
      end
      if (cmd.scan_start) begin
        scan_cnt_r <= '0;
      end else if (scan_go) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      k_vld_r <= scan_go;
    end
  end

  always_ff @(posedge clk) begin
    upd_addr_r <= in_data.sample[ADDR_W-1:0];
    wr_addr_r  <= upd_addr_r;
    wr_data_r  <= upd_val;
    k_r        <= scan_cnt_r;
    if (k_vld_r) begin
      if (k_r == '0) begin
        win_a_r <= '0;
      end else begin
        win_a_r <= win_b_r;
        if (k_r == CNT_W'(1) || smooth > best_val_r) begin
          best_val_r <= smooth;
          best_idx_r <= j_idx;
        end
        if (j_idx == TIE_BIN) begin
          tie_val_r <= smooth;
        end
      end
      win_b_r <= k_cin;
    end
    if (cmd.finish) begin
      // tie bin wins any tie it is part of, else lowest maximal index
      out_r.mode_value  <= (tie_val_r == best_val_r) ? TIE_BIN : best_idx_r;
      out_r.range_error <= error_r;
    end
  end

  assign status.scan_done = k_vld_r && k_r[ADDR_W];
  assign out_data         = out_r;

endmodule
`default_nettype wire

// ----- design/shm_ctrl.sv -----
// Controller: sequences counting, drain, bin scan and result hand-off.
`default_nettype none
module shm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  input  logic                 out_ready,
  input  shm_pkg::dp_status_t  status,
  output logic                 in_ready,
  output logic                 out_valid,
  output shm_pkg::dp_cmd_t     cmd
);
  import shm_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready       = (state_r == ST_RUN);
  assign cmd.count      = (state_r == ST_RUN) && in_valid;
  assign cmd.scan_start = (state_r == ST_DRAIN);
  assign cmd.scan_step  = (state_r == ST_SCAN);
  assign cmd.finish     = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign out_valid      = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces one taken in the same cycle
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_RUN: begin
          if (in_valid && in_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // lets the last request's write land before the scan reads
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (status.scan_done) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd.finish) begin
            state_r <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/smoothed_histogram_mode.sv -----
// Top level: smoothed 256-bin histogram mode finder.
// Input channel in_valid/in_ready/in_data carries one sample per request, with
// a last mark closing a set. Samples above 255 are not counted and raise
// range_error in that set's result.
// Output channel out_valid/out_ready/out_data carries one result per set: the
// bin with the largest smoothed count (bin 128 wins ties, else the lowest bin)
// and the error flag.
// Throughput: one sample request per cycle within a set; each bin update is a
// read then write of the count memory, with forwarding between neighbours.
// After the last request of a set is accepted, the drain state and the 257-step
// scan over the count memory (one read a cycle) come before the result is offered.
// in_ready is low from the last request until the result is loaded into the
// output register.
// A stalled receiver holds the result; the next set starts counting meanwhile
// and its own result waits until the previous one has been taken.
// Reset (rst_n low, synchronous) clears the histogram and error flag at once
// through per-bin valid bits, so no clearing pass is needed.
`default_nettype none
module smoothed_histogram_mode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  shm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output shm_pkg::out_item_t  out_data
);
  import shm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  shm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  shm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
